[hw/rtl/scsa_pkg.sv]
// Shared types and codes for the size-class slab allocator.
// Request and result words, status codes; no dependencies.
package scsa_pkg;

  typedef enum logic [2:0] {
    ST_ALLOC    = 3'd0,
    ST_OVERSIZE = 3'd1,
    ST_FULL     = 3'd2,
    ST_FREED    = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  localparam logic [31:0] RESET_BASE = 32'h5800_0000;
  // class 0 holds 16 byte blocks
  localparam int unsigned MIN_SHIFT  = 4;

  typedef struct packed {
    req_type_t   req_type;
    logic [31:0] request_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] block_address;
    status_t     status;
    logic [3:0]  size_class;
    logic [31:0] oversize_total;
    logic [31:0] full_total;
    logic [47:0] waste_total;
  } result_t;

endpackage

[hw/rtl/scsa_stack_mem.sv]
// Free-stack store: one write port, one read port, registered read data.
// Standalone; no package needed.
module scsa_stack_mem #(
  parameter int unsigned DEPTH = 20480,
  parameter int unsigned DW    = 11
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DW-1:0]                           wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DW-1:0]                           rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/scsa_count_mem.sv]
// Per-class count store (free depth and bump count) with valid bits.
// An entry never written since reset reads as zero. No package needed.
module scsa_count_mem #(
  parameter int unsigned DEPTH = 10,
  parameter int unsigned DW    = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DW-1:0]                           wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DW-1:0]                           rdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DW-1:0]    rd_word;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_word <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

[hw/rtl/size_class_slab_allocator_unit.sv]
// Size-class slab allocator, top level: class decode, control sequencer,
// running totals. Uses scsa_pkg, scsa_count_mem and scsa_stack_mem.
//
//  channel   | ports                    | handshake
//  ----------+--------------------------+--------------------------------
//  request   | start, busy, req         | taken when start && !busy
//  result    | done, result             | done high for one cycle, no stall
//  config    | cfg_we, cfg_wdata        | region_base written when cfg_we
//
// Each request walks decode, count read, finish; the result word shows in
// the cycle after finish. A new request is taken in the finish cycle, so
// one request can overlap the last step of the one before. The count memory
// is read in decode and the stack memory in count read, in sequence.
// Synchronous reset clears totals and count valid bits at once; no sweep.
// Results cannot be held off; the block never stalls on its output.
module size_class_slab_allocator_unit
  import scsa_pkg::*;
#(
  parameter int unsigned NUM_CLASSES  = 10,
  parameter int unsigned SLOT_CAP     = 2048,
  parameter int unsigned REGION_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        done,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned CW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned SW     = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;
  localparam int unsigned NW     = $clog2(SLOT_CAP + 1);
  localparam int unsigned DEPTH  = NUM_CLASSES * SLOT_CAP;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CSZ_W  = NUM_CLASSES + MIN_SHIFT;

  function automatic int unsigned slots_of(int unsigned c);
    int unsigned n;
    n = REGION_BYTES >> (MIN_SHIFT + c);
    return (n > SLOT_CAP) ? SLOT_CAP : n;
  endfunction

  function automatic int unsigned span_of(int unsigned c);
    return slots_of(c) << (MIN_SHIFT + c);
  endfunction

  function automatic int unsigned offset_of(int unsigned c);
    int unsigned acc;
    acc = 0;
    for (int unsigned i = 0; i < c; i++) begin
      acc = acc + span_of(i);
    end
    return acc;
  endfunction

  typedef enum logic [1:0] {IDLE, DEC, CNT, FIN} state_t;

  state_t         state;
  logic           accept;

  // request hold
  req_type_t      req_kind;
  logic [31:0]    size_hold;
  logic [31:0]    rel_base;     // free address less region base
  logic           faddr_zero;
  logic [31:0]    region_base;

  // decode stage
  logic [NUM_CLASSES-1:0] fits;
  logic [NUM_CLASSES-1:0] hits;
  logic [SW-1:0]          fslot     [NUM_CLASSES];
  logic [NW-1:0]          slots_tab [NUM_CLASSES];
  logic [31:0]            off_tab   [NUM_CLASSES];
  logic [AW-1:0]          mbase_tab [NUM_CLASSES];
  logic                   dec_found;
  logic [CW-1:0]          dec_cls;
  logic                   found;
  logic [CW-1:0]          cls;
  logic [SW-1:0]          free_slot;

  // count stage
  logic [2*NW-1:0]  cnt_rdata;
  logic [2*NW-1:0]  cnt_wdata;
  logic             cnt_we;
  logic             cnt_re;
  logic [NW-1:0]    fc;
  logic [NW-1:0]    bc;
  logic [NW-1:0]    slots_c;
  logic [AW-1:0]    mbase_c;
  logic [CSZ_W-1:0] csz_c;
  logic             stk_we;
  logic             stk_re;
  logic [AW-1:0]    stk_waddr;
  logic [AW-1:0]    stk_raddr;
  logic [SW-1:0]    stk_rdata;
  status_t          st_next;
  logic             pop_next;
  logic [SW-1:0]    slot_next;
  logic [3:0]       cls_out_next;

  // finish stage
  status_t          st_hold;
  logic             popped;
  logic [SW-1:0]    slot_hold;
  logic [3:0]       cls_out;
  logic [CSZ_W-1:0] waste_diff;
  logic             waste_en;
  logic [31:0]      cbase;
  logic [4:0]       shamt;
  logic [SW-1:0]    fin_slot;
  logic [31:0]      fin_addr;

  logic [31:0]      oversize_cnt;
  logic [31:0]      full_cnt;
  logic [47:0]      waste_cnt;
  logic [31:0]      oversize_next;
  logic [31:0]      full_next;
  logic [47:0]      waste_next;

  assign busy   = (state == DEC) || (state == CNT);
  assign accept = start && !busy;

  // per-class constant tables and parallel range tests
  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cls
    localparam int unsigned SH    = MIN_SHIFT + g;
    localparam int unsigned SLOTS = slots_of(g);
    localparam int unsigned SPAN  = span_of(g);
    localparam int unsigned OFF   = offset_of(g);
    logic [31:0] rel;

    assign rel          = rel_base - 32'(OFF);
    assign fits[g]      = size_hold <= (32'd1 << SH);
    assign hits[g]      = rel < 32'(SPAN);
    assign fslot[g]     = SW'(rel >> SH);
    assign slots_tab[g] = NW'(SLOTS);
    assign off_tab[g]   = 32'(OFF);
    assign mbase_tab[g] = AW'(g * SLOT_CAP);
  end

  // lowest matching class wins
  always_comb begin
    dec_found = 1'b0;
    dec_cls   = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if ((req_kind == REQ_ALLOC) ? fits[c] : hits[c]) begin
        dec_found = 1'b1;
        dec_cls   = CW'(c);
      end
    end
    if (req_kind == REQ_FREE && faddr_zero) begin
      dec_found = 1'b0;
    end
  end

  assign cnt_re = (state == DEC);

  assign fc      = cnt_rdata[2*NW-1:NW];
  assign bc      = cnt_rdata[NW-1:0];
  assign slots_c = slots_tab[cls];
  assign mbase_c = mbase_tab[cls];
  assign csz_c   = CSZ_W'(1) << (MIN_SHIFT + cls);

  assign stk_raddr = AW'(32'(mbase_c) + 32'(fc) - 32'd1);
  assign stk_waddr = AW'(32'(mbase_c) + 32'(fc));

  always_comb begin
    cnt_we       = 1'b0;
    cnt_wdata    = cnt_rdata;
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    st_next      = ST_IGNORED;
    pop_next     = 1'b0;
    slot_next    = '0;
    cls_out_next = '0;
    if (state == CNT) begin
      if (req_kind == REQ_ALLOC) begin
        if (!found) begin
          st_next = ST_OVERSIZE;
        end else begin
          cls_out_next = 4'(cls);
          if (fc != '0) begin
            st_next   = ST_ALLOC;
            pop_next  = 1'b1;
            stk_re    = 1'b1;
            cnt_we    = 1'b1;
            cnt_wdata = {fc - NW'(1), bc};
          end else if (bc < slots_c) begin
            st_next   = ST_ALLOC;
            slot_next = SW'(bc);
            cnt_we    = 1'b1;
            cnt_wdata = {fc, bc + NW'(1)};
          end else begin
            st_next = ST_FULL;
          end
        end
      end else if (found && (fc < slots_c)) begin
        st_next      = ST_FREED;
        cls_out_next = 4'(cls);
        stk_we       = 1'b1;
        cnt_we       = 1'b1;
        cnt_wdata    = {fc + NW'(1), bc};
      end
    end
  end

  assign fin_slot = popped ? stk_rdata : slot_hold;
  assign fin_addr = cbase + (32'(fin_slot) << shamt);

  assign oversize_next = oversize_cnt + ((st_hold == ST_OVERSIZE) ? 32'd1 : 32'd0);
  assign full_next     = full_cnt + ((st_hold == ST_FULL) ? 32'd1 : 32'd0);
  assign waste_next    = waste_cnt + (waste_en ? 48'(waste_diff) : 48'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      done         <= 1'b0;
      region_base  <= RESET_BASE;
      oversize_cnt <= '0;
      full_cnt     <= '0;
      waste_cnt    <= '0;
    end else begin
      done <= (state == FIN);
      if (cfg_we) begin
        region_base <= cfg_wdata;
      end
      if (accept) begin
        req_kind   <= req.req_type;
        size_hold  <= req.request_size;
        rel_base   <= req.free_address - region_base;
        faddr_zero <= (req.free_address == 32'd0);
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state <= DEC;
          end
        end
        DEC: begin
          found     <= dec_found;
          cls       <= dec_cls;
          free_slot <= fslot[dec_cls];
          state     <= CNT;
        end
        CNT: begin
          st_hold    <= st_next;
          popped     <= pop_next;
          slot_hold  <= slot_next;
          cls_out    <= cls_out_next;
          waste_diff <= CSZ_W'(32'(csz_c) - size_hold);
          waste_en   <= (req_kind == REQ_ALLOC) && found;
          cbase      <= region_base + off_tab[cls];
          shamt      <= 5'(MIN_SHIFT) + 5'(cls);
          state      <= FIN;
        end
        FIN: begin
          oversize_cnt          <= oversize_next;
          full_cnt              <= full_next;
          waste_cnt             <= waste_next;
          result.block_address  <= (st_hold == ST_ALLOC) ? fin_addr : 32'd0;
          result.status         <= st_hold;
          result.size_class     <= cls_out;
          result.oversize_total <= oversize_next;
          result.full_total     <= full_next;
          result.waste_total    <= waste_next;
          state                 <= accept ? DEC : IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  scsa_count_mem #(
    .DEPTH (NUM_CLASSES),
    .DW    (2 * NW)
  ) u_count_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (cnt_we),
    .waddr (cls),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (dec_cls),
    .rdata (cnt_rdata)
  );

  scsa_stack_mem #(
    .DEPTH (DEPTH),
    .DW    (SW)
  ) u_stack_mem (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (free_slot),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // a result word only ever follows the finish cycle
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == FIN))
    else $error("result word without a finish cycle");

  // counts are written back before the next request reads them
  a_cnt_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cnt_we && cnt_re))
    else $error("count memory read and write overlap");

  // a pop read always lands in the finish cycle
  a_pop_to_fin: assert property (@(posedge clk) disable iff (rst)
    stk_re |=> (state == FIN) && popped)
    else $error("stack read not consumed in finish");

  a_stk_single: assert property (@(posedge clk) disable iff (rst)
    !(stk_re && stk_we))
    else $error("stack read and write in one cycle");

  a_totals: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.oversize_total == oversize_cnt) &&
             (result.full_total == full_cnt) &&
             (result.waste_total == waste_cnt))
    else $error("reported totals differ from held counters");

endmodule
